>>> rtl/sfsp_pkg.sv
// Shared types, constants and phase tables for the full-step stepper positioner.
// No dependencies; used by every module in rtl/.
package sfsp_pkg;

  localparam int unsigned CYCLE_COUNT_BITS_DEF = 24;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] STEPS_PER_CM_RST = 16'd2968;
  localparam logic [7:0]  STEP_DELAY_RST   = 8'd1;
  localparam logic [7:0]  MAX_POS_RST      = 8'd47;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STEPS_PER_CM = 2'd0,
    CFG_STEP_DELAY   = 2'd1,
    CFG_MAX_POS      = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_MOVE = 1'b1
  } func_t;

  typedef struct packed {
    logic       func;
    logic [7:0] target_cm;
    logic       limit_switch_n;
  } in_item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       busy_res;
    logic [7:0] position_cm;
    logic       stopped_by_limit;
  } out_item_t;

  // command decode handed from the move planner to the top level
  typedef struct packed {
    logic       refuse;
    logic       right;
    logic       zero;
    logic [7:0] tgt;
  } move_plan_t;

  function automatic logic [3:0] phase_coils(input logic right, input logic [1:0] idx);
    logic [3:0] c;
    case (idx)
      2'd0:    c = right ? 4'b1001 : 4'b0110;
      2'd1:    c = 4'b0011;
      2'd2:    c = right ? 4'b0110 : 4'b1001;
      2'd3:    c = 4'b1100;
      default: c = 4'b0000;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/sfsp_move_calc.sv
// Move planner: clamps the target, picks direction, rounds the cycle count.
// Depends on sfsp_pkg.
module sfsp_move_calc #(
  parameter int unsigned CYCLE_COUNT_BITS = sfsp_pkg::CYCLE_COUNT_BITS_DEF
) (
  input  logic [7:0]                  position,
  input  logic [7:0]                  target,
  input  logic [7:0]                  max_pos,
  input  logic [15:0]                 steps_q8,
  output sfsp_pkg::move_plan_t        plan,
  output logic [CYCLE_COUNT_BITS-1:0] cycles
);
  import sfsp_pkg::*;

  localparam int unsigned QW = 17;  // (16b x 8b + 128) >> 8
  localparam int unsigned EW = CYCLE_COUNT_BITS + QW;

  logic [7:0]  tgt;
  logic        right;
  logic [7:0]  diff;
  logic [23:0] prod;
  logic [24:0] rounded;
  logic [QW-1:0] q;
  logic [EW-1:0] q_ext;
  logic [EW-1:0] cap_ext;
  logic          sat;

  always_comb begin
    tgt   = (target > max_pos) ? max_pos : target;
    right = (tgt >= position);
    diff  = right ? (tgt - position) : (position - tgt);
    prod    = {8'd0, steps_q8} * {16'd0, diff};
    rounded = {1'b0, prod} + 25'd128;
    q       = rounded[24:8];
    q_ext   = {{CYCLE_COUNT_BITS{1'b0}}, q};
    cap_ext = {{QW{1'b0}}, {CYCLE_COUNT_BITS{1'b1}}};
    sat     = (q_ext > cap_ext);
    cycles  = sat ? {CYCLE_COUNT_BITS{1'b1}} : q_ext[CYCLE_COUNT_BITS-1:0];

    plan.tgt    = tgt;
    plan.right  = right;
    plan.zero   = (cycles == '0);
    // already at the end in the direction of travel
    plan.refuse = (right && (position >= max_pos)) || (!right && (position == 8'd0));
  end

endmodule

>>> rtl/stepper_full_step_positioner.sv
// Full-step stepper positioner, top level: input stage, state update, result register.
// Each input transfer passes the input register and then the result register; throughput is
// one item per cycle while out_ready stays high.
// The state update and the cycle-count multiply sit between the input and result registers.
// Reset (rst_n low, synchronous): idle, position 0, coils 0000, registers to defaults.
// Depends on sfsp_pkg and sfsp_move_calc.
module stepper_full_step_positioner #(
  parameter int unsigned CYCLE_COUNT_BITS = sfsp_pkg::CYCLE_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfsp_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfsp_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [sfsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfsp_pkg::*;

  localparam int unsigned CB = CYCLE_COUNT_BITS;

  // configuration
  logic [15:0] steps_q8_r;
  logic [7:0]  step_delay_r;
  logic [7:0]  max_pos_r;

  // pipeline
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      advance;

  // positioner state
  logic [7:0]    position_r, position_nxt;
  logic          moving_r, moving_nxt;
  logic          right_r, right_nxt;
  logic [CB-1:0] cycles_r, cycles_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    delay_r, delay_nxt;
  logic [7:0]    target_r, target_nxt;
  logic          limit_r, limit_nxt;
  logic [3:0]    coil_r, coil_nxt;

  move_plan_t    plan;
  logic [CB-1:0] plan_cycles;
  logic [7:0]    delay_lim;
  logic [7:0]    delay_inc;

  sfsp_move_calc #(.CYCLE_COUNT_BITS(CB)) u_calc (
    .position (position_r),
    .target   (s1_data_r.target_cm),
    .max_pos  (max_pos_r),
    .steps_q8 (steps_q8_r),
    .plan     (plan),
    .cycles   (plan_cycles)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_comb begin
    position_nxt = position_r;
    moving_nxt   = moving_r;
    right_nxt    = right_r;
    cycles_nxt   = cycles_r;
    phase_nxt    = phase_r;
    delay_nxt    = delay_r;
    target_nxt   = target_r;
    limit_nxt    = limit_r;
    coil_nxt     = coil_r;
    delay_lim    = (step_delay_r == 8'd0) ? 8'd1 : step_delay_r;
    delay_inc    = delay_r + 8'd1;

    if (advance) begin
      if (s1_data_r.func == FUNC_MOVE) begin
        if (!moving_r && !plan.refuse) begin
          target_nxt = plan.tgt;
          right_nxt  = plan.right;
          cycles_nxt = plan.zero ? '0 : plan_cycles;
          phase_nxt  = 2'd0;
          delay_nxt  = 8'd0;
          coil_nxt   = 4'b0000;
          limit_nxt  = 1'b0;
          if (plan.zero) begin
            position_nxt = plan.tgt;
          end else begin
            moving_nxt = 1'b1;
          end
        end
      end else if (moving_r) begin
        if (delay_inc < delay_lim) begin
          delay_nxt = delay_inc;
        end else begin
          delay_nxt = 8'd0;
          // cycle boundary: finish when done, abort on a pressed switch
          if ((phase_r == 2'd0) && ((cycles_r == '0) || !s1_data_r.limit_switch_n)) begin
            moving_nxt   = 1'b0;
            position_nxt = target_r;
            coil_nxt     = 4'b0000;
            cycles_nxt   = '0;
            phase_nxt    = 2'd0;
            limit_nxt    = (cycles_r != '0);
          end else begin
            coil_nxt  = phase_coils(right_r, phase_r);
            phase_nxt = phase_r + 2'd1;
            if (phase_r == 2'd3) begin
              cycles_nxt = cycles_r - {{(CB-1){1'b0}}, 1'b1};
            end
          end
        end
      end
    end

    out_nxt = out_r;
    if (advance) begin
      out_nxt.coils            = moving_nxt ? coil_nxt : 4'b0000;
      out_nxt.busy_res         = moving_nxt;
      out_nxt.position_cm      = position_nxt;
      out_nxt.stopped_by_limit = limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_q8_r   <= STEPS_PER_CM_RST;
      step_delay_r <= STEP_DELAY_RST;
      max_pos_r    <= MAX_POS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STEPS_PER_CM: steps_q8_r   <= cfg_wdata;
        CFG_STEP_DELAY:   step_delay_r <= cfg_wdata[7:0];
        CFG_MAX_POS:      max_pos_r    <= cfg_wdata[7:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      position_r  <= 8'd0;
      moving_r    <= 1'b0;
      right_r     <= 1'b0;
      cycles_r    <= '0;
      phase_r     <= 2'd0;
      delay_r     <= 8'd0;
      target_r    <= 8'd0;
      limit_r     <= 1'b0;
      coil_r      <= 4'b0000;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      position_r  <= position_nxt;
      moving_r    <= moving_nxt;
      right_r     <= right_nxt;
      cycles_r    <= cycles_nxt;
      phase_r     <= phase_nxt;
      delay_r     <= delay_nxt;
      target_r    <= target_nxt;
      limit_r     <= limit_nxt;
      coil_r      <= coil_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_data_r <= in_data;
    end
    out_r <= out_nxt;
  end

  a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.busy_res) |-> (out_r.coils == 4'b0000))
    else $error("coils driven while idle");

  a_phase_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 2'd0) |-> moving_r)
    else $error("phase advanced outside a move");

  a_idle_coil_reg: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> (coil_r == 4'b0000))
    else $error("coil register set while idle");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(position_r) && $stable(moving_r) && $stable(cycles_r)))
    else $error("state changed without a transfer");

endmodule

>>> tb/stepper_full_step_positioner_check.sv
`timescale 1ns / 1ps
// Status checker for the full-step stepper positioner: predicts one status item per input
// transfer and compares each output transfer against the oldest prediction.
// Depends on sfsp_pkg (item structs, register indexes, reset values).
module stepper_full_step_positioner_check #(
  parameter int unsigned CYCLE_COUNT_BITS = sfsp_pkg::CYCLE_COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sfsp_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sfsp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [sfsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);
  import sfsp_pkg::*;

  // coil patterns, phase 0 in the low nibble
  localparam logic [15:0] LEFT_SEQ  = 16'hC936;
  localparam logic [15:0] RIGHT_SEQ = 16'hC639;
  localparam longint unsigned CYC_MAX = (64'd1 << CYCLE_COUNT_BITS) - 64'd1;
  localparam int PRINT_CAP = 60;

  logic [15:0] spc_q8;
  logic [7:0]  delay_ticks;
  logic [7:0]  max_cm;

  logic [7:0]                  pos_cm;
  logic                        in_motion;
  logic                        dir_right;
  logic [CYCLE_COUNT_BITS-1:0] cycles_rem;
  logic [1:0]                  phase;
  logic [7:0]                  tick_cnt;
  logic [7:0]                  dest_cm;
  logic                        limit_hit;
  logic [3:0]                  coil_q;

  out_item_t expected_status[$];

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < PRINT_CAP)
      $display("%0t: status mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic end_move(input logic by_limit);
    in_motion = 1'b0;
    pos_cm = dest_cm;
    coil_q = 4'h0;
    cycles_rem = '0;
    phase = 2'd0;
    tick_cnt = 8'd0;
    limit_hit = by_limit;
  endtask

  task automatic step_model(input in_item_t it);
    logic [7:0] tgt;
    logic [7:0] diff;
    logic [7:0] lim;
    logic right;
    longint unsigned cyc;
    if (it.func == FUNC_MOVE) begin
      if (in_motion) return;
      tgt = (it.target_cm > max_cm) ? max_cm : it.target_cm;
      right = (tgt >= pos_cm);
      // already at the end in the requested direction
      if (right && pos_cm >= max_cm) return;
      if (!right && pos_cm == 8'd0) return;
      diff = right ? tgt - pos_cm : pos_cm - tgt;
      cyc = 64'(spc_q8) * 64'(diff);
      cyc = (cyc + 64'd128) >> 8;
      if (cyc > CYC_MAX) cyc = CYC_MAX;
      dest_cm = tgt;
      dir_right = right;
      if (cyc == 64'd0) begin
        end_move(1'b0);
        return;
      end
      in_motion = 1'b1;
      cycles_rem = cyc[CYCLE_COUNT_BITS-1:0];
      phase = 2'd0;
      tick_cnt = 8'd0;
      coil_q = 4'h0;
      limit_hit = 1'b0;
    end else begin
      if (!in_motion) return;
      lim = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt < lim) return;
      tick_cnt = 8'd0;
      // cycle boundary: out of cycles or switch pressed ends the move
      if (phase == 2'd0) begin
        if (cycles_rem == '0) begin
          end_move(1'b0);
          return;
        end
        if (!it.limit_switch_n) begin
          end_move(1'b1);
          return;
        end
      end
      coil_q = dir_right ? RIGHT_SEQ[{phase, 2'b00} +: 4] : LEFT_SEQ[{phase, 2'b00} +: 4];
      if (phase == 2'd3) cycles_rem = cycles_rem - CYCLE_COUNT_BITS'(1);
      phase = phase + 2'd1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t now_status;
    if (!rst_n) begin
      spc_q8 = STEPS_PER_CM_RST;
      delay_ticks = STEP_DELAY_RST;
      max_cm = MAX_POS_RST;
      pos_cm = 8'd0;
      in_motion = 1'b0;
      dir_right = 1'b0;
      cycles_rem = '0;
      phase = 2'd0;
      tick_cnt = 8'd0;
      dest_cm = 8'd0;
      limit_hit = 1'b0;
      coil_q = 4'h0;
      expected_status.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 32'(out_data));
        end else begin
          want = expected_status.pop_front();
          if (out_data.coils != want.coils)
            report_mismatch("coils", 32'(want.coils), 32'(out_data.coils));
          if (out_data.busy_res != want.busy_res)
            report_mismatch("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
          if (out_data.position_cm != want.position_cm)
            report_mismatch("position_cm", 32'(want.position_cm),
                            32'(out_data.position_cm));
          if (out_data.stopped_by_limit != want.stopped_by_limit)
            report_mismatch("stopped_by_limit", 32'(want.stopped_by_limit),
                            32'(out_data.stopped_by_limit));
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_STEPS_PER_CM: spc_q8 = cfg_wdata[15:0];
          CFG_STEP_DELAY:   delay_ticks = cfg_wdata[7:0];
          CFG_MAX_POS:      max_cm = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_model(in_data);
        now_status.coils = in_motion ? coil_q : 4'h0;
        now_status.busy_res = in_motion;
        now_status.position_cm = pos_cm;
        now_status.stopped_by_limit = limit_hit;
        expected_status.push_back(now_status);
      end
      outstanding = expected_status.size();
    end
  end

endmodule

>>> tb/stepper_full_step_positioner_test.sv
`timescale 1ns / 1ps
// Top of the stepper positioner testbench: clock, reset, stimulus, flow control and verdict.
// Depends on sfsp_pkg, the positioner RTL and stepper_full_step_positioner_check.
module stepper_full_step_positioner_test;
  import sfsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  stepper_full_step_positioner uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  stepper_full_step_positioner_check status_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // result side: random stalls, plus a long hold-off whenever hold_seq moves
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[stepper_full_step_positioner] ERROR");
      $finish;
    end
  end

  function automatic in_item_t mk_item(input func_t f, input logic [7:0] tgt,
                                       input logic sw_n);
    in_item_t it;
    it.func = f;
    it.target_cm = tgt;
    it.limit_switch_n = sw_n;
    return it;
  endfunction

  // mostly ticks with the switch released; commands aimed near the travel range
  function automatic in_item_t random_item(input int maxp);
    in_item_t it;
    int hi;
    hi = (maxp + 2 > 255) ? 255 : maxp + 2;
    it.limit_switch_n = ($urandom_range(99) >= 6);
    if ($urandom_range(99) < 18) begin
      it.func = FUNC_MOVE;
      it.target_cm = ($urandom_range(99) < 80) ? 8'($urandom_range(hi))
                                                : 8'($urandom_range(255));
    end else begin
      it.func = FUNC_TICK;
      it.target_cm = 8'($urandom);
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input in_item_t it);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config(input logic [15:0] steps, input logic [7:0] delay,
                             input logic [7:0] maxp);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_STEPS_PER_CM;
    cfg_wdata <= steps;
    @(negedge clk);
    cfg_addr <= CFG_STEP_DELAY;
    cfg_wdata <= {8'h00, delay};
    @(negedge clk);
    cfg_addr <= CFG_MAX_POS;
    cfg_wdata <= {8'h00, maxp};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] steps;
    logic [7:0]  delay;
    logic [7:0]  maxp;
    int          n_items;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on the reset settings
    send_item(mk_item(FUNC_TICK, 8'hFF, 1'b0));  // tick while idle
    send_item(mk_item(FUNC_MOVE, 8'h00, 1'b1));  // move to the current position: zero cycles, not refused
    send_item(mk_item(FUNC_MOVE, 8'hFF, 1'b1));  // clamped to max, long move
    send_item(mk_item(FUNC_MOVE, 8'h0A, 1'b1));  // command while moving
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b0));  // abort on the first cycle check
    send_item(mk_item(FUNC_MOVE, 8'hC8, 1'b1));  // right move at the right end: refused
    send_item(mk_item(FUNC_MOVE, 8'd46, 1'b1));  // one cm left
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b1));
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b0));  // pressed mid-cycle: not checked
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b1));
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b1));
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b0));
    send_item(mk_item(FUNC_MOVE, 8'd46, 1'b1));  // zero cycles, clears the limit flag
    send_item(mk_item(FUNC_MOVE, 8'd47, 1'b1));  // one cm right
    send_item(mk_item(FUNC_TICK, 8'h55, 1'b1));
    send_item(mk_item(FUNC_TICK, 8'hAA, 1'b1));
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b1));
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b1));
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b0));
    send_item(mk_item(FUNC_MOVE, 8'h00, 1'b0));  // switch level ignored by commands
    send_item(mk_item(FUNC_TICK, 8'h00, 1'b0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin steps = 16'd256;   delay = 8'd1;   maxp = 8'd10;  gap_pct = 0;  stall_pct = 0;  end
        1: begin steps = 16'd64;    delay = 8'd2;   maxp = 8'd20;  gap_pct = 65; stall_pct = 0;  end
        2: begin steps = 16'd128;   delay = 8'd1;   maxp = 8'd12;  gap_pct = 0;  stall_pct = 65; end
        3: begin steps = 16'd1;     delay = 8'd255; maxp = 8'd255; gap_pct = 20; stall_pct = 20; end
        4: begin steps = 16'd2968;  delay = 8'd1;   maxp = 8'd3;   gap_pct = 0;  stall_pct = 0;  end
        5: begin steps = 16'hFFFF;  delay = 8'd1;   maxp = 8'd1;   gap_pct = 65; stall_pct = 0;  end
        6: begin steps = 16'd300;   delay = 8'd3;   maxp = 8'd8;   gap_pct = 0;  stall_pct = 65; end
        default: begin
          // zero delay behaves like one tick per phase
          steps = 16'd40; delay = 8'd0; maxp = 8'd30; gap_pct = 20; stall_pct = 20;
        end
      endcase
      n_items = 235;
      load_config(steps, delay, maxp);
      for (int k = 0; k < n_items; k++) begin
        if (p == 0 && k == 40) hold_seq++;
        send_item(random_item(maxp));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("[stepper_full_step_positioner] OK");
    else
      $display("[stepper_full_step_positioner] ERROR");
    $finish;
  end

endmodule
